@@ rtl/stt_pkg.sv @@
// Package for the scene text tokenizer: mode encoding, result record,
// character constants and field codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BARE = 3'd1,
    MODE_STR  = 3'd2,
    MODE_ESC  = 3'd3,
    MODE_CMT  = 3'd4,
    MODE_HALT = 3'd5
  } mode_e;

  localparam logic [1:0] KIND_BARE    = 2'd0;
  localparam logic [1:0] KIND_STRING  = 2'd1;
  localparam logic [1:0] KIND_BRACKET = 2'd2;
  localparam logic [1:0] KIND_COMMENT = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_END_STR   = 2'd1;
  localparam logic [1:0] ERR_NL_STR    = 2'd2;
  localparam logic [1:0] ERR_BAD_ESC   = 2'd3;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] kind;
    logic       first;
    logic       last;
    logic [1:0] error_code;
    logic       stream_done;
    logic       final_of_item;
  } result_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       held_first;
  } state_t;

endpackage

`default_nettype wire

@@ rtl/stt_if.sv @@
// Valid/ready channel interfaces for the tokenizer input and result items.
// No dependencies; the result fields are declared as plain signals.
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;

  modport source (output valid, output op, output byte_in, input ready);
  modport sink (input valid, input op, input byte_in, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] kind;
  logic       first;
  logic       last;
  logic [1:0] error_code;
  logic       stream_done;
  logic       final_of_item;

  modport source (output valid, output byte_out, output kind, output first, output last,
                  output error_code, output stream_done, output final_of_item,
                  input ready);
  modport sink (input valid, input byte_out, input kind, input first, input last,
                input error_code, input stream_done, input final_of_item,
                output ready);
endinterface

`default_nettype wire

@@ rtl/stt_step.sv @@
// Per-item tokenizer step: next mode, held byte and up to two result items.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_step (
  input  stt_pkg::state_t  state_i,
  input  logic             op_i,
  input  logic [7:0]       byte_i,
  output stt_pkg::state_t  state_o,
  output logic [1:0]       res_cnt_o,
  output stt_pkg::result_t res0_o,
  output stt_pkg::result_t res1_o
);
  import stt_pkg::*;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [8:0] decode_esc(input logic [7:0] b);
    logic [8:0] d;
    case (b)
      CH_LOW_B:  d = {1'b0, CH_BS};
      CH_LOW_F:  d = {1'b0, CH_FF};
      CH_LOW_N:  d = {1'b0, CH_LF};
      CH_LOW_R:  d = {1'b0, CH_CR};
      CH_LOW_T:  d = {1'b0, CH_TAB};
      CH_BSLASH: d = {1'b0, CH_BSLASH};
      CH_SQUOTE: d = {1'b0, CH_SQUOTE};
      CH_DQUOTE: d = {1'b0, CH_DQUOTE};
      default:   d = 9'h100;
    endcase
    return d;
  endfunction

  function automatic result_t mk(input logic [7:0] b, input logic [1:0] k, input logic f,
                                 input logic l, input logic [1:0] e, input logic d);
    result_t r;
    r.byte_out      = b;
    r.kind          = k;
    r.first         = f;
    r.last          = l;
    r.error_code    = e;
    r.stream_done   = d;
    r.final_of_item = 1'b0;
    return r;
  endfunction

  logic       flush_en;
  logic [1:0] flush_kind;
  logic       flush_last;
  logic       put_en;
  result_t    put_rec;
  logic       flush_v;
  result_t    flush_rec;
  logic [8:0] esc;

  always_comb begin
    state_o    = state_i;
    flush_en   = 1'b0;
    flush_kind = KIND_BARE;
    flush_last = 1'b0;
    put_en     = 1'b0;
    put_rec    = mk(8'h00, KIND_BARE, 1'b0, 1'b0, ERR_NONE, 1'b0);
    esc        = decode_esc(byte_i);
    if (state_i.mode != MODE_HALT) begin
      if (op_i == OP_END) begin
        if ((state_i.mode == MODE_STR) || (state_i.mode == MODE_ESC)) begin
          put_en     = 1'b1;
          put_rec    = mk(8'h00, KIND_STRING, 1'b0, 1'b0, ERR_END_STR, 1'b1);
          state_o.mode = MODE_HALT;
        end else begin
          flush_en   = (state_i.mode == MODE_BARE) || (state_i.mode == MODE_CMT);
          flush_kind = (state_i.mode == MODE_CMT) ? KIND_COMMENT : KIND_BARE;
          flush_last = 1'b1;
          put_en     = 1'b1;
          put_rec    = mk(8'h00, KIND_BARE, 1'b0, 1'b0, ERR_NONE, 1'b1);
          state_o.mode = MODE_IDLE;
        end
        state_o.held_valid = 1'b0;
      end else begin
        case (state_i.mode)
          MODE_BARE: begin
            flush_en   = 1'b1;
            flush_kind = KIND_BARE;
            flush_last = 1'b1;
            if (is_ws(byte_i)) begin
              state_o.mode       = MODE_IDLE;
              state_o.held_valid = 1'b0;
            end else if (byte_i == CH_DQUOTE) begin
              state_o = '{MODE_STR, byte_i, 1'b1, 1'b1};
            end else if ((byte_i == CH_LBRK) || (byte_i == CH_RBRK)) begin
              put_en             = 1'b1;
              put_rec            = mk(byte_i, KIND_BRACKET, 1'b1, 1'b1, ERR_NONE, 1'b0);
              state_o.mode       = MODE_IDLE;
              state_o.held_valid = 1'b0;
            end else begin
              flush_last = 1'b0;
              state_o    = '{MODE_BARE, byte_i, 1'b1, 1'b0};
            end
          end
          MODE_CMT: begin
            flush_en   = 1'b1;
            flush_kind = KIND_COMMENT;
            if ((byte_i == CH_CR) || (byte_i == CH_LF)) begin
              flush_last         = 1'b1;
              state_o.mode       = MODE_IDLE;
              state_o.held_valid = 1'b0;
            end else begin
              state_o = '{MODE_CMT, byte_i, 1'b1, 1'b0};
            end
          end
          MODE_STR: begin
            flush_kind = KIND_STRING;
            if (byte_i == CH_DQUOTE) begin
              flush_en           = 1'b1;
              put_en             = 1'b1;
              put_rec            = mk(byte_i, KIND_STRING, 1'b0, 1'b1, ERR_NONE, 1'b0);
              state_o.mode       = MODE_IDLE;
              state_o.held_valid = 1'b0;
            end else if (byte_i == CH_LF) begin
              put_en             = 1'b1;
              put_rec            = mk(byte_i, KIND_STRING, 1'b0, 1'b0, ERR_NL_STR, 1'b0);
              state_o.mode       = MODE_HALT;
              state_o.held_valid = 1'b0;
            end else if (byte_i == CH_BSLASH) begin
              state_o.mode = MODE_ESC;
            end else begin
              flush_en = 1'b1;
              state_o  = '{MODE_STR, byte_i, 1'b1, 1'b0};
            end
          end
          MODE_ESC: begin
            flush_kind = KIND_STRING;
            if (esc[8]) begin
              put_en             = 1'b1;
              put_rec            = mk(byte_i, KIND_STRING, 1'b0, 1'b0, ERR_BAD_ESC, 1'b0);
              state_o.mode       = MODE_HALT;
              state_o.held_valid = 1'b0;
            end else begin
              flush_en = 1'b1;
              state_o  = '{MODE_STR, esc[7:0], 1'b1, 1'b0};
            end
          end
          default: begin
            state_o.held_valid = 1'b0;
            if (is_ws(byte_i)) begin
              state_o.mode = MODE_IDLE;
            end else if (byte_i == CH_DQUOTE) begin
              state_o = '{MODE_STR, byte_i, 1'b1, 1'b1};
            end else if ((byte_i == CH_LBRK) || (byte_i == CH_RBRK)) begin
              put_en       = 1'b1;
              put_rec      = mk(byte_i, KIND_BRACKET, 1'b1, 1'b1, ERR_NONE, 1'b0);
              state_o.mode = MODE_IDLE;
            end else if (byte_i == CH_HASH) begin
              state_o = '{MODE_CMT, byte_i, 1'b1, 1'b1};
            end else begin
              state_o = '{MODE_BARE, byte_i, 1'b1, 1'b1};
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    flush_v   = flush_en && state_i.held_valid;
    flush_rec = mk(state_i.held_byte, flush_kind, state_i.held_first, flush_last,
                   ERR_NONE, 1'b0);
    res_cnt_o = {1'b0, flush_v} + {1'b0, put_en};
    res0_o    = flush_v ? flush_rec : put_rec;
    res1_o    = put_rec;
    res0_o.final_of_item = !(flush_v && put_en);
    res1_o.final_of_item = 1'b1;
  end

endmodule

`default_nettype wire

@@ rtl/scene_text_tokenizer.sv @@
// Scene text tokenizer top level: state registers, step logic and a
// four-entry result queue. Depends on stt_pkg, stt_if and stt_step.
// A result is written into the queue when its item is accepted and reaches the output from the queue head.
// Throughput: one item per cycle while the queue has room for two results;
//   an item with two results is read out as two queue entries, one per pop of the read port.
// Reset: mode idle, no held byte, queue empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scene_text_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  state_t                 state_q, state_d;
  logic [1:0]             res_cnt;
  result_t                res0, res1;
  result_t                queue_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   accept;
  logic                   pop;
  logic [1:0]             push_n;
  state_t                 step_state;
  result_t                head;

  stt_step u_step (
    .state_i   (state_q),
    .op_i      (in_i.op),
    .byte_i    (in_i.byte_in),
    .state_o   (step_state),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  assign in_i.ready = (count_q <= (QueuePtrW + 1)'(QueueDepth - 2));
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;
  assign push_n     = accept ? res_cnt : 2'd0;

  always_comb begin
    state_d  = accept ? step_state : state_q;
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_n);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(pop);
    count_d  = count_q + (QueuePtrW + 1)'(push_n) - (QueuePtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '{MODE_IDLE, 8'h00, 1'b0, 1'b0};
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= res1;
    end
  end

  assign head = queue_q[rd_ptr_q];

  assign out_o.valid         = (count_q != '0);
  assign out_o.byte_out      = head.byte_out;
  assign out_o.kind          = head.kind;
  assign out_o.first         = head.first;
  assign out_o.last          = head.last;
  assign out_o.error_code    = head.error_code;
  assign out_o.stream_done   = head.stream_done;
  assign out_o.final_of_item = head.final_of_item;

endmodule

`default_nettype wire
